FILE: design/msl_pkg.sv
// shared types, constants and header helpers for the mp4 sample locator
package msl_pkg;

	localparam int SAMPLE_DEPTH = 4096;
	localparam int CHUNK_DEPTH  = 1024;
	localparam int RUN_DEPTH    = 64;

	localparam int SAW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int CAW = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
	localparam int RAW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
	localparam int RCW = $clog2(RUN_DEPTH + 1);

	localparam logic [10:0] CHUNK_MAX = 11'h7FF;

	// opcodes of an input item
	localparam logic [2:0] OP_LOAD_SIZE  = 3'd0;
	localparam logic [2:0] OP_LOAD_CHUNK = 3'd1;
	localparam logic [2:0] OP_LOAD_RUN   = 3'd2;
	localparam logic [2:0] OP_RESTART    = 3'd3;
	localparam logic [2:0] OP_NEXT       = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_END      = 2'd1;
	localparam logic [1:0] ST_TOO_BIG  = 2'd2;
	localparam logic [1:0] ST_NO_CHUNK = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_DEFAULT_SIZE = 3'd0;
	localparam logic [2:0] REG_SAMPLE_COUNT = 3'd1;
	localparam logic [2:0] REG_RUN_COUNT    = 3'd2;
	localparam logic [2:0] REG_SAMPLE_RATE  = 3'd3;
	localparam logic [2:0] REG_CHANNELS     = 3'd4;
	localparam logic [2:0] REG_BUFFER       = 3'd5;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [11:0] entry_index;
		logic [31:0] entry_value;
		logic [15:0] run_samples;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] file_offset;
		logic [12:0] frame_bytes;
		logic [12:0] total_bytes;
		logic [55:0] adts_header;
	} result_t;

	typedef struct packed {
		logic [12:0] default_sample_size;
		logic [12:0] sample_count;
		logic [6:0]  run_entry_count;
		logic [16:0] sample_rate_hz;
		logic [2:0]  channel_count;
		logic [12:0] buffer_bytes;
	} cfg_t;

	// command kinds after classification in the front part
	typedef enum logic [2:0] {
		K_NOP, K_LOAD_SIZE, K_LOAD_CHUNK, K_LOAD_RUN, K_RESTART, K_NEXT
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [11:0] idx;
		logic [31:0] val;
		logic [15:0] rs;
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE, S_RST, S_SIZE, S_COFF, S_SCAN, S_EMIT
	} state_t;

	function automatic logic [3:0] freq_index(input logic [16:0] hz);
		priority if (hz >= 17'd96000) return 4'd0;
		else if (hz >= 17'd88200) return 4'd1;
		else if (hz >= 17'd64000) return 4'd2;
		else if (hz >= 17'd48000) return 4'd3;
		else if (hz >= 17'd44100) return 4'd4;
		else if (hz >= 17'd32000) return 4'd5;
		else if (hz >= 17'd24000) return 4'd6;
		else if (hz >= 17'd22050) return 4'd7;
		else if (hz >= 17'd16000) return 4'd8;
		else if (hz >= 17'd12000) return 4'd9;
		else return 4'd4;
	endfunction

	// aac-lc adts header without crc, first byte most significant
	function automatic logic [55:0] make_header(input logic [12:0] len,
			input logic [16:0] hz, input logic [2:0] ch);
		return {8'hFF, 8'hF1, 2'b01, freq_index(hz), 1'b0, ch[2],
			ch[1:0], 4'b0000, len[12:11], len[10:3], len[2:0], 5'h1F, 8'hFC};
	endfunction

endpackage

FILE: design/msl_ram.sv
// generic single-write, single-read ram with registered read data
module msl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: design/msl_front.sv
// front part: accepts items, classifies them and queues commands
module msl_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  msl_pkg::item_t  item,
	output logic            cmd_valid,
	output msl_pkg::cmd_t   cmd,
	input  logic            cmd_pop
);
	import msl_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       take;

	// classify; loads beyond a table become no-ops
	always_comb begin
		cls.idx = item.entry_index;
		cls.val = item.entry_value;
		cls.rs  = item.run_samples;
		unique case (item.opcode)
			OP_LOAD_SIZE:  cls.kind = (32'(item.entry_index) < SAMPLE_DEPTH) ? K_LOAD_SIZE : K_NOP;
			OP_LOAD_CHUNK: cls.kind = (32'(item.entry_index) < CHUNK_DEPTH) ? K_LOAD_CHUNK : K_NOP;
			OP_LOAD_RUN:   cls.kind = (32'(item.entry_index) < RUN_DEPTH) ? K_LOAD_RUN : K_NOP;
			OP_RESTART:    cls.kind = K_RESTART;
			OP_NEXT:       cls.kind = K_NEXT;
			default:       cls.kind = K_NOP;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign take      = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_q];

	// two-entry command queue
	always_ff @(posedge clk) begin
		if (take)
			slot_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (take)
				wr_q <= !wr_q;
			if (cmd_pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, take} - {1'b0, cmd_pop};
		end
	end
endmodule

FILE: design/msl_back.sv
// back part: table memories, frame locator sequencer and result register
module msl_back (
	input  logic             clk,
	input  logic             arst_n,
	input  msl_pkg::cfg_t    cfg,
	input  logic             cmd_valid,
	input  msl_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	output logic             empty,
	input  logic             pop,
	output msl_pkg::result_t result
);
	import msl_pkg::*;

	state_t state_q, state_d;

	logic [12:0] sample_q;
	logic [10:0] chunk_q, nchunk_q;
	logic [15:0] taken_q, limit_q;
	logic [31:0] noff_q;
	logic [13:0] frame_q;
	logic        adv_q;
	logic [RCW-1:0] ri_q;
	logic        rv_q;
	result_t     res_q;
	logic        res_v_q;

	logic        slot_free;
	logic        emit;
	result_t     emit_res;

	// memory ports
	logic           sz_we, ck_we, rn_we;
	logic [SAW-1:0] sz_ra;
	logic [CAW-1:0] ck_ra;
	logic [RAW-1:0] rn_ra;
	logic [13:0]    sz_rd;
	logic [31:0]    ck_rd, rn_rd;

	msl_ram #(.WIDTH(14), .DEPTH(SAMPLE_DEPTH)) u_size (
		.clk(clk), .we(sz_we), .waddr(SAW'(cmd.idx)), .wdata(cmd.val[13:0]),
		.raddr(sz_ra), .rdata(sz_rd));
	msl_ram #(.WIDTH(32), .DEPTH(CHUNK_DEPTH)) u_chunk (
		.clk(clk), .we(ck_we), .waddr(CAW'(cmd.idx)), .wdata(cmd.val),
		.raddr(ck_ra), .rdata(ck_rd));
	msl_ram #(.WIDTH(32), .DEPTH(RUN_DEPTH)) u_run (
		.clk(clk), .we(rn_we), .waddr(RAW'(cmd.idx)), .wdata({cmd.val[15:0], cmd.rs}),
		.raddr(rn_ra), .rdata(rn_rd));

	// scan bound, clamped to the run table depth
	logic [RCW-1:0] run_n;
	assign run_n = (32'(cfg.run_entry_count) >= RUN_DEPTH) ? RCW'(RUN_DEPTH)
		: RCW'(cfg.run_entry_count);

	// frame size and its length check
	logic [13:0] fr;
	logic [14:0] flen;
	assign fr   = (cfg.default_sample_size != 13'd0) ? {1'b0, cfg.default_sample_size} : sz_rd;
	assign flen = {1'b0, fr} + 15'd7;

	// run entry check during the scan
	logic scan_stop, scan_done;
	assign scan_stop = rv_q && (rn_rd[31:16] > {5'd0, nchunk_q});
	assign scan_done = scan_stop || (ri_q >= run_n);

	assign slot_free = !res_v_q || pop;
	assign empty     = !res_v_q;
	assign result    = res_q;

	// next state, memory controls and result
	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		sz_we    = 1'b0;
		ck_we    = 1'b0;
		rn_we    = 1'b0;
		sz_ra    = SAW'(sample_q);
		ck_ra    = CAW'(chunk_q);
		rn_ra    = RAW'(ri_q);
		emit     = 1'b0;
		emit_res = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && slot_free) begin
					cmd_pop = 1'b1;
					unique case (cmd.kind)
						K_LOAD_SIZE:  begin sz_we = 1'b1; emit = 1'b1; end
						K_LOAD_CHUNK: begin ck_we = 1'b1; emit = 1'b1; end
						K_LOAD_RUN:   begin rn_we = 1'b1; emit = 1'b1; end
						K_NOP:        emit = 1'b1;
						K_RESTART: begin
							ck_ra   = '0;
							rn_ra   = '0;
							state_d = S_RST;
						end
						K_NEXT: begin
							if (sample_q >= cfg.sample_count ||
									(cfg.default_sample_size == 13'd0 &&
									32'(sample_q) >= SAMPLE_DEPTH)) begin
								emit            = 1'b1;
								emit_res.status = ST_END;
							end else begin
								state_d = S_SIZE;
							end
						end
						default: emit = 1'b1;
					endcase
				end
			end
			S_RST: begin
				emit    = 1'b1;
				state_d = S_IDLE;
			end
			S_SIZE: begin
				if (flen > {2'b00, cfg.buffer_bytes}) begin
					emit            = 1'b1;
					emit_res.status = ST_TOO_BIG;
					state_d         = S_IDLE;
				end else if (taken_q >= limit_q) begin
					if (chunk_q == CHUNK_MAX || 32'(chunk_q) >= CHUNK_DEPTH) begin
						emit            = 1'b1;
						emit_res.status = ST_NO_CHUNK;
						state_d         = S_IDLE;
					end else begin
						state_d = S_COFF;
					end
				end else begin
					state_d = S_EMIT;
				end
			end
			S_COFF: begin
				rn_ra   = '0;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (scan_done)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				emit                 = 1'b1;
				emit_res.status      = ST_OK;
				emit_res.file_offset = noff_q;
				emit_res.frame_bytes = frame_q[12:0];
				emit_res.total_bytes = frame_q[12:0] + 13'd7;
				emit_res.adts_header = make_header(frame_q[12:0] + 13'd7,
					cfg.sample_rate_hz, cfg.channel_count);
				state_d              = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// locator state and work registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
			chunk_q  <= 11'd1;
			taken_q  <= '0;
			limit_q  <= '0;
			noff_q   <= '0;
			nchunk_q <= 11'd1;
			frame_q  <= '0;
			adv_q    <= 1'b0;
			ri_q     <= '0;
			rv_q     <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_RST: begin
					sample_q <= '0;
					chunk_q  <= 11'd1;
					taken_q  <= '0;
					limit_q  <= rn_rd[15:0];
					noff_q   <= ck_rd;
				end
				S_SIZE: begin
					frame_q  <= fr;
					adv_q    <= (taken_q >= limit_q);
					nchunk_q <= chunk_q + 11'd1;
				end
				S_COFF: begin
					noff_q <= ck_rd;
					ri_q   <= RCW'(1);
					rv_q   <= (run_n != '0);
				end
				S_SCAN: begin
					// entry ri_q-1 is on the read port; issue the next one
					if (rv_q && !scan_stop)
						limit_q <= rn_rd[15:0];
					rv_q <= !scan_done;
					if (!scan_done)
						ri_q <= ri_q + RCW'(1);
				end
				S_EMIT: begin
					noff_q   <= noff_q + 32'(frame_q);
					sample_q <= sample_q + 13'd1;
					taken_q  <= adv_q ? 16'd1 : taken_q + 16'd1;
					if (adv_q)
						chunk_q <= nchunk_q;
				end
				default: ;
			endcase
			if (emit)
				res_v_q <= 1'b1;
			else if (pop)
				res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			res_q <= emit_res;
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && res_q.status != ST_OK |-> res_q.frame_bytes == 13'd0 &&
		res_q.adts_header == 56'd0 && res_q.file_offset == 32'd0)
		else $error("error result carries payload");
	// frame results always carry a nonzero total; other items carry zeros
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && res_q.status == ST_OK && res_q.total_bytes != 13'd0 |->
		res_q.total_bytes == res_q.frame_bytes + 13'd7)
		else $error("total length mismatch");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> ri_q <= run_n + RCW'(1))
		else $error("run scan past table");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> slot_free)
		else $error("result written over a waiting one");
endmodule

FILE: design/mp4_sample_locator_adts.sv
// top level: configuration registers, front queue and locator back end
// Locates the frames of one mp4 audio track and builds their adts headers.
// Load items fill the size, chunk-offset and run tables; restart rewinds;
// each next-frame item returns offset, size, total length and header or an
// end or error status. Items are taken through a two-entry command queue
// and done one at a time by the back end: a load or unknown item in the
// idle state, restart through the rewind state, a next-frame item through
// the size and emit states (ending in idle at end of samples, in size when
// the frame is too big or the chunk is past the table); one opening a new
// chunk adds chunk-offset and a run scan on the run table's single read
// port. A one-item output register holds results; back end stalls if full.
module mp4_sample_locator_adts (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  msl_pkg::item_t     item,
	output logic               empty,
	input  logic               pop,
	output msl_pkg::result_t   result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import msl_pkg::*;

	cfg_t       cfg_q;
	logic       cmd_valid, cmd_pop;
	cmd_t       cmd;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign ridx   = paddr[4:2];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_sample_size <= '0;
			cfg_q.sample_count        <= '0;
			cfg_q.run_entry_count     <= '0;
			cfg_q.sample_rate_hz      <= 17'd44100;
			cfg_q.channel_count       <= 3'd2;
			cfg_q.buffer_bytes        <= 13'd8191;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_DEFAULT_SIZE: cfg_q.default_sample_size <= pwdata[12:0];
				REG_SAMPLE_COUNT: cfg_q.sample_count        <= pwdata[12:0];
				REG_RUN_COUNT:    cfg_q.run_entry_count     <= pwdata[6:0];
				REG_SAMPLE_RATE:  cfg_q.sample_rate_hz      <= pwdata[16:0];
				REG_CHANNELS:     cfg_q.channel_count       <= pwdata[2:0];
				REG_BUFFER:       cfg_q.buffer_bytes        <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// configuration reads
	always_comb begin
		unique case (ridx)
			REG_DEFAULT_SIZE: prdata = 32'(cfg_q.default_sample_size);
			REG_SAMPLE_COUNT: prdata = 32'(cfg_q.sample_count);
			REG_RUN_COUNT:    prdata = 32'(cfg_q.run_entry_count);
			REG_SAMPLE_RATE:  prdata = 32'(cfg_q.sample_rate_hz);
			REG_CHANNELS:     prdata = 32'(cfg_q.channel_count);
			REG_BUFFER:       prdata = 32'(cfg_q.buffer_bytes);
			default:          prdata = '0;
		endcase
	end

	msl_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop));

	msl_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_pop(cmd_pop), .empty(empty), .pop(pop), .result(result));
endmodule

FILE: tb/mp4_sample_locator_adts_checker.sv
// result checker and frame locator predictor for the mp4 sample locator
`timescale 1ns / 100ps

module mp4_sample_locator_adts_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             full,
	input  msl_pkg::item_t   item,
	input  logic             empty,
	input  logic             pop,
	input  msl_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic             pready,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output int               errors,
	output int               outstanding
);
	import msl_pkg::*;

	// track tables
	logic [13:0] frame_size_tab [SAMPLE_DEPTH];
	logic [31:0] chunk_ofs_tab [CHUNK_DEPTH];
	logic [15:0] run_first_tab [RUN_DEPTH];
	logic [15:0] run_spc_tab [RUN_DEPTH];

	// register copies
	logic [12:0] fixed_size, n_samples, buf_size;
	logic [6:0]  n_runs;
	logic [16:0] rate_hz;
	logic [2:0]  chans;

	// read position
	logic [12:0] cur_sample;
	logic [10:0] cur_chunk;
	logic [15:0] used_in_chunk, chunk_limit;
	logic [31:0] cur_offset;

	result_t pending_frames[$];
	int      results_seen;

	// adts sampling frequency index, thresholds reached from above
	function automatic logic [3:0] rate_code(input logic [16:0] hz);
		int unsigned steps[10];
		steps = '{96000, 88200, 64000, 48000, 44100, 32000, 24000, 22050, 16000, 12000};
		for (int k = 0; k < 10; k++)
			if (hz >= steps[k]) return k[3:0];
		return 4'd4;
	endfunction

	// seven header bytes for a given total length
	function automatic logic [55:0] adts_bytes(input logic [12:0] len);
		logic [7:0] b2, b3, b4, b5;
		b2 = {2'b01, rate_code(rate_hz), 1'b0, chans[2]};
		b3 = {chans[1:0], 4'b0000, len[12:11]};
		b4 = len[10:3];
		b5 = {len[2:0], 5'h1F};
		return {8'hFF, 8'hF1, b2, b3, b4, b5, 8'hFC};
	endfunction

	// work out the result of one item and advance the track state
	function automatic result_t locate_frame(input item_t it);
		result_t     r;
		int unsigned frame, chk, tk, lim, n;
		r = '0;
		case (it.opcode)
			OP_LOAD_SIZE: begin
				if (it.entry_index < SAMPLE_DEPTH)
					frame_size_tab[it.entry_index] = it.entry_value[13:0];
			end
			OP_LOAD_CHUNK: begin
				if (it.entry_index < CHUNK_DEPTH)
					chunk_ofs_tab[it.entry_index] = it.entry_value;
			end
			OP_LOAD_RUN: begin
				if (it.entry_index < RUN_DEPTH) begin
					run_first_tab[it.entry_index] = it.entry_value[15:0];
					run_spc_tab[it.entry_index] = it.run_samples;
				end
			end
			OP_RESTART: begin
				cur_sample = '0;
				cur_chunk = 11'd1;
				used_in_chunk = '0;
				chunk_limit = run_spc_tab[0];
				cur_offset = chunk_ofs_tab[0];
			end
			OP_NEXT: begin
				if (cur_sample >= n_samples) begin
					r.status = ST_END;
					return r;
				end
				frame = fixed_size;
				if (frame == 0) begin
					if (cur_sample >= SAMPLE_DEPTH) begin
						r.status = ST_END;
						return r;
					end
					frame = frame_size_tab[cur_sample];
				end
				if (frame + 7 > buf_size) begin
					r.status = ST_TOO_BIG;
					return r;
				end
				chk = cur_chunk;
				tk = used_in_chunk;
				lim = chunk_limit;
				// chunk used up: move on and rescan the runs
				if (tk >= lim) begin
					chk++;
					if (chk > CHUNK_MAX || chk - 1 >= CHUNK_DEPTH) begin
						r.status = ST_NO_CHUNK;
						return r;
					end
					tk = 0;
					cur_offset = chunk_ofs_tab[chk - 1];
					n = (n_runs > RUN_DEPTH) ? RUN_DEPTH : n_runs;
					for (int k = 0; k < n; k++) begin
						if (run_first_tab[k] > chk) break;
						lim = run_spc_tab[k];
					end
				end
				r.status = ST_OK;
				r.file_offset = cur_offset;
				r.frame_bytes = frame[12:0];
				r.total_bytes = frame[12:0] + 13'd7;
				r.adts_header = adts_bytes(frame[12:0] + 13'd7);
				cur_offset = cur_offset + frame;
				cur_sample = cur_sample + 13'd1;
				used_in_chunk = tk[15:0] + 16'd1;
				cur_chunk = chk[10:0];
				chunk_limit = lim[15:0];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch on result %0d, %s: got %h, want %h", results_seen, what, got, want);
		errors++;
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_size <= '0;
			n_samples <= '0;
			n_runs <= '0;
			rate_hz <= 17'd44100;
			chans <= 3'd2;
			buf_size <= 13'd8191;
			cur_sample <= '0;
			cur_chunk <= 11'd1;
			used_in_chunk <= '0;
			chunk_limit <= '0;
			cur_offset <= '0;
			pending_frames.delete();
			outstanding <= 0;
			errors <= 0;
			results_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_DEFAULT_SIZE: fixed_size = pwdata[12:0];
					REG_SAMPLE_COUNT: n_samples = pwdata[12:0];
					REG_RUN_COUNT:    n_runs = pwdata[6:0];
					REG_SAMPLE_RATE:  rate_hz = pwdata[16:0];
					REG_CHANNELS:     chans = pwdata[2:0];
					REG_BUFFER:       buf_size = pwdata[12:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (pending_frames.size() == 0) begin
					$display("mismatch: result %0d arrived with nothing expected", results_seen);
					errors++;
				end else begin
					result_t want;
					want = pending_frames.pop_front();
					if (result.status !== want.status)
						flag("status", result.status, want.status);
					if (result.file_offset !== want.file_offset)
						flag("file_offset", result.file_offset, want.file_offset);
					if (result.frame_bytes !== want.frame_bytes)
						flag("frame_bytes", result.frame_bytes, want.frame_bytes);
					if (result.total_bytes !== want.total_bytes)
						flag("total_bytes", result.total_bytes, want.total_bytes);
					if (result.adts_header !== want.adts_header)
						flag("adts_header", result.adts_header, want.adts_header);
				end
				results_seen++;
			end
			if (push && !full)
				pending_frames.push_back(locate_frame(item));
			outstanding = pending_frames.size();
		end
	end

endmodule

FILE: tb/mp4_sample_locator_adts_tb.sv
// stimulus and verdict for the mp4 sample locator testbench
`timescale 1ns / 100ps

module mp4_sample_locator_adts_tb;
	import msl_pkg::*;

	// table entries loaded up front; tracks stay short enough to read only these
	localparam int SIZE_FILL  = 48;
	localparam int CHUNK_FILL = 48;
	localparam int TRACK_MAX  = 47;

	logic        clk;
	logic        arst_n;
	logic        push, full, empty, pop;
	item_t       item;
	result_t     result;
	logic        psel, penable, pwrite, pready;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          errors, outstanding;
	logic        calm;
	int          pop_hold;

	mp4_sample_locator_adts DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	mp4_sample_locator_adts_checker frame_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
		.errors(errors), .outstanding(outstanding)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	// result side stalls in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_hold <= 0;
		end else if (pop_hold > 0) begin
			pop_hold <= pop_hold - 1;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			pop_hold <= $urandom_range(0, 3);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	function automatic item_t mk(input logic [2:0] op, input logic [31:0] idx,
			input logic [31:0] val, input logic [31:0] rs);
		item_t it;
		it.opcode = op;
		it.entry_index = idx[11:0];
		it.entry_value = val;
		it.run_samples = rs[15:0];
		return it;
	endfunction

	// offer one item, idling in random bursts first
	task automatic send(input item_t it);
		if (!calm && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
	endtask

	// stop sending and wait for every expected result
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_track(input int dflt, input int cnt, input int runs, input int hz,
			input int ch, input int bufsz);
		reg_write(REG_DEFAULT_SIZE, dflt);
		reg_write(REG_SAMPLE_COUNT, cnt);
		reg_write(REG_RUN_COUNT, runs);
		reg_write(REG_SAMPLE_RATE, hz);
		reg_write(REG_CHANNELS, ch);
		reg_write(REG_BUFFER, bufsz);
	endtask

	function automatic int pick_rate();
		int unsigned rates[12];
		rates = '{96000, 88200, 64000, 48000, 44100, 32000, 24000, 22050, 16000,
			12000, 0, 131071};
		case ($urandom_range(0, 2))
			0: return rates[$urandom_range(0, 11)];
			1: return rates[$urandom_range(0, 9)] - 1;
			default: return $urandom_range(0, 131071);
		endcase
	endfunction

	// one random item, mostly frame requests
	function automatic item_t random_item();
		int    roll;
		logic [31:0] v;
		roll = $urandom_range(0, 99);
		v = $urandom();
		if (roll < 70) return mk(OP_NEXT, $urandom(), $urandom(), $urandom());
		if (roll < 78) return mk(OP_RESTART, $urandom(), $urandom(), $urandom());
		if (roll < 83) begin
			if ($urandom_range(0, 1)) v[13:0] = 14'($urandom_range(0, 3000));
			return mk(OP_LOAD_SIZE, $urandom(), v, $urandom());
		end
		if (roll < 88) return mk(OP_LOAD_CHUNK, $urandom(), v, $urandom());
		if (roll < 94) begin
			if ($urandom_range(0, 3) != 0) v[15:0] = 16'($urandom_range(0, 40));
			return mk(OP_LOAD_RUN, $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom(),
				v, $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom());
		end
		return mk(3'($urandom_range(5, 7)), $urandom(), $urandom(), $urandom());
	endfunction

	initial begin
		int first;
		logic [31:0] v;
		calm = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored opcodes, out-of-range loads, end of samples at reset
		send(mk(3'd5, 'hFFF, 'hFFFF_FFFF, 'hFFFF));
		send(mk(3'd6, 0, 0, 0));
		send(mk(3'd7, 'hABC, 'h1234_5678, 'h5555));
		send(mk(OP_LOAD_CHUNK, 'hFFF, 'hDEAD_BEEF, 0));
		send(mk(OP_LOAD_RUN, 'h040, 'h0000_0001, 'h0003));
		send(mk(OP_LOAD_RUN, 0, 'hFFFF_0001, 'h0002));
		send(mk(OP_LOAD_CHUNK, 0, 'hFFFF_FFF0, 'hFFFF));
		send(mk(OP_RESTART, 0, 0, 0));
		send(mk(OP_NEXT, 0, 0, 0));

		// fill the table entries that the short tracks below can reach
		for (int k = 0; k < SIZE_FILL; k++) begin
			v = $urandom();
			v[13:0] = ($urandom_range(0, 19) == 0) ? 14'd8184 : 14'($urandom_range(0, 2000));
			send(mk(OP_LOAD_SIZE, k, v, $urandom()));
		end
		for (int k = 0; k < CHUNK_FILL; k++)
			send(mk(OP_LOAD_CHUNK, k, $urandom_range(0, 3) ? $urandom() : 'hFFFF_F000,
				$urandom()));
		first = 1;
		for (int k = 0; k < RUN_DEPTH; k++) begin
			v = $urandom();
			v[15:0] = 16'(first);
			send(mk(OP_LOAD_RUN, k, v, $urandom_range(0, 6)));
			first += $urandom_range(0, 3);
		end
		drain();

		// every frame opens a new chunk until the samples run out
		set_track(8184, TRACK_MAX, 0, 96000, 7, 8191);
		send(mk(OP_LOAD_RUN, 0, 1, 0));
		send(mk(OP_RESTART, 0, 0, 0));
		repeat (TRACK_MAX + 2) send(mk(OP_NEXT, $urandom(), $urandom(), $urandom()));
		drain();

		// random phases under several register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_track(0, 0, 0, 0, 0, 0);
				1: set_track(8184, TRACK_MAX, 64, 96000, 7, 8191);
				2: set_track(0, TRACK_MAX, 127, 131071, 5, 4000);
				default: set_track($urandom_range(0, 2) ? 0 : $urandom_range(0, 8184),
					$urandom_range(0, TRACK_MAX), $urandom_range(0, 64), pick_rate(),
					$urandom_range(0, 7),
					$urandom_range(0, 3) ? 8191 : $urandom_range(0, 8191));
			endcase
			if (ph == 5) calm = 1'b1;
			send(mk(OP_RESTART, $urandom(), $urandom(), $urandom()));
			repeat (30) send(random_item());
			drain();
		end

		if (errors == 0 && outstanding == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/msl_pkg.sv
design/msl_ram.sv
design/msl_front.sv
design/msl_back.sv
design/mp4_sample_locator_adts.sv
tb/mp4_sample_locator_adts_checker.sv
tb/mp4_sample_locator_adts_tb.sv
